FILE: rtl/smx_pkg.sv
// Shared constants, register codes and control structs for the stereo gain/fade mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smx_pkg;

   // default datapath sizing
   localparam int SAMPLE_BITS_DEF    = 32;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int PORT_W        = 32;
   localparam int CLIP_W        = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REPLAY_GAIN_W = 24;
   localparam int RAMP_STEP_W   = 17;
   localparam int FPS_W         = 16;
   localparam int MODE_W        = 2;
   localparam int POL_W         = 2;

   // register reset values
   localparam logic [REPLAY_GAIN_W-1:0] REPLAY_GAIN_RST = 24'd65536;
   localparam logic [CLIP_W-1:0]        CLIP_HIGH_RST   = 32'h7FFF_FFFF;
   localparam logic [CLIP_W-1:0]        CLIP_LOW_RST    = 32'h8000_0000;
   localparam logic [FPS_W-1:0]         FPS_RST         = 16'd4410;

   // register index map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPLAY_GAIN     = 3'd0,
      CSR_CLIP_HIGH       = 3'd1,
      CSR_CLIP_LOW        = 3'd2,
      CSR_POLARITY        = 3'd3,
      CSR_CHANNEL_MODE    = 3'd4,
      CSR_TRANSITION_MODE = 3'd5,
      CSR_RAMP_STEP       = 3'd6,
      CSR_FRAMES_PER_STEP = 3'd7
   } smx_csr_type;

   // channel_mode codes (codes other than these behave as left-to-right copy)
   localparam logic [MODE_W-1:0] CH_PASS     = 2'd0;
   localparam logic [MODE_W-1:0] CH_COPY_R2L = 2'd2;

   // transition_mode codes (the unused code and zero mean no transition)
   localparam logic [MODE_W-1:0] TR_FADE  = 2'd1;
   localparam logic [MODE_W-1:0] TR_XFADE = 2'd2;

   // per-cycle stage strobes from the sequencer to the lanes
   typedef struct packed {
      logic load;
      logic gain;
      logic pol;
      logic fade;
   } smx_step_type;

   // transition flags that apply to one frame
   typedef struct packed {
      logic fade;
      logic xfade;
   } smx_frame_type;

endpackage

FILE: rtl/smx_ramp.sv
// Transition controller: arms fades and crossfades, ramps the fade gain per frame.
// Depends on smx_pkg.
`timescale 1ns / 1ps

module smx_ramp #(
   parameter int   GAIN_FRAC_BITS = 16,
   localparam int  RW = ((GAIN_FRAC_BITS > 17) ? GAIN_FRAC_BITS : 17) + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               track_start,
   input  logic                               old_present,
   input  logic [smx_pkg::MODE_W-1:0]         transition_mode,
   input  logic [smx_pkg::RAMP_STEP_W-1:0]    ramp_step,
   input  logic [smx_pkg::FPS_W-1:0]          frames_per_step,
   output smx_pkg::smx_frame_type             frame,
   output logic [RW-1:0]                      ramp_gain
);
   import smx_pkg::*;

   localparam logic [RW-1:0] GAIN_ONE = RW'(1) << GAIN_FRAC_BITS;

   logic              fade_ff, fade_in, xfade_ff, xfade_in;
   logic [RW-1:0]     ramp_ff, ramp_in;
   logic [FPS_W-1:0]  count_ff, count_in;

   logic              fade_v, xfade_v, arm;
   logic [RW-1:0]     gain_v;
   logic [FPS_W-1:0]  count_v, fps_eff;

   assign fps_eff = (frames_per_step == '0) ? FPS_W'(1) : frames_per_step;
   assign arm     = (ramp_step != '0) &&
                    ((transition_mode == TR_FADE) ||
                     ((transition_mode == TR_XFADE) && old_present));

   // flags for the frame being taken, and the state it leaves behind
   always_comb begin
      fade_v  = fade_ff;
      xfade_v = xfade_ff;
      gain_v  = ramp_ff;
      count_v = count_ff;
      if (track_start) begin
         fade_v  = 1'b0;
         xfade_v = 1'b0;
         if (arm) begin
            fade_v  = 1'b1;
            xfade_v = (transition_mode == TR_XFADE);
            gain_v  = '0;
            count_v = '0;
         end
      end
      // overlap ran out: this frame passes unfaded
      if (fade_v && xfade_v && !old_present) begin
         fade_v  = 1'b0;
         xfade_v = 1'b0;
      end

      fade_in  = fade_v;
      xfade_in = xfade_v;
      ramp_in  = gain_v;
      count_in = count_v;
      if (fade_v) begin
         count_in = count_v + FPS_W'(1);
         if (count_in >= fps_eff) begin
            count_in = '0;
            ramp_in  = gain_v + RW'(ramp_step);
         end
         if (ramp_in >= GAIN_ONE) begin
            fade_in  = 1'b0;
            xfade_in = 1'b0;
         end
      end
   end

   assign frame.fade  = fade_v;
   assign frame.xfade = xfade_v;
   assign ramp_gain   = gain_v;

   // state advances once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff  <= 1'b0;
         xfade_ff <= 1'b0;
         ramp_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         fade_ff  <= fade_in;
         xfade_ff <= xfade_in;
         ramp_ff  <= ramp_in;
         count_ff <= count_in;
      end
   end

   a_xfade_needs_fade : assert property (@(posedge clock) disable iff (reset)
      xfade_ff |-> fade_ff)
      else $error("crossfade flag set without fade flag");

   a_gain_below_one : assert property (@(posedge clock) disable iff (reset)
      fade_ff |-> (ramp_ff < GAIN_ONE))
      else $error("fade still running with ramp gain at or above one");

   a_frame_flags : assert property (@(posedge clock) disable iff (reset)
      (accept && !fade_ff && !track_start) |-> !frame.fade)
      else $error("fade applied without an armed transition");

endmodule

FILE: rtl/smx_lane.sv
// One channel lane: clip/track gain, polarity, then fade or crossfade mix.
// Depends on smx_pkg; stepped by the sequencer in the top level.
`timescale 1ns / 1ps

module smx_lane #(
   parameter int  SAMPLE_BITS    = 32,
   parameter int  GAIN_FRAC_BITS = 16,
   localparam int GW = ((GAIN_FRAC_BITS + 1 > 24) ? GAIN_FRAC_BITS + 1 : 24),
   localparam int RW = ((GAIN_FRAC_BITS > 17) ? GAIN_FRAC_BITS : 17) + 1
) (
   input  logic                                clock,
   input  smx_pkg::smx_step_type               step,
   input  smx_pkg::smx_frame_type              frame,
   input  logic [GW-1:0]                       gain,
   input  logic                                bypass,
   input  logic                                invert,
   input  logic signed [smx_pkg::CLIP_W-1:0]   clip_high,
   input  logic signed [smx_pkg::CLIP_W-1:0]   clip_low,
   input  logic signed [SAMPLE_BITS-1:0]       sample_in,
   input  logic signed [SAMPLE_BITS-1:0]       old_in,
   input  logic [RW-1:0]                       ramp_in,
   output logic signed [SAMPLE_BITS-1:0]       sample_out
);
   import smx_pkg::*;

   localparam int SW    = SAMPLE_BITS;
   localparam int FB    = GAIN_FRAC_BITS;
   localparam int ONE_W = FB + 1;
   localparam int GP_W  = GW + 1 + SW;
   localparam int NP_W  = RW + 1 + SW;
   localparam int OP_W  = ONE_W + 1 + SW;
   localparam logic [RW-1:0] GAIN_ONE = RW'(1) << FB;
   localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   logic signed [SW-1:0]     smp_ff, old_ff, gs_ff, gs_in;
   logic [RW-1:0]            ig_ff;
   logic [ONE_W-1:0]         og_ff;
   logic [RW-1:0]            og_full;
   logic signed [GP_W-1:0]   gprod_ff, gprod_in;
   logic                     hi_ff, lo_ff;
   logic signed [NP_W-1:0]   nprod_ff, nprod_in;
   logic signed [OP_W-1:0]   oprod_ff, oprod_in;
   logic signed [CLIP_W-1:0] smp_wide;
   logic signed [SW-1:0]     clipped, nsh, osh;

   // capture the beat; weight of the old frame is one minus the ramp gain
   assign og_full = GAIN_ONE - ramp_in;

   always_ff @(posedge clock) begin
      if (step.load) begin
         smp_ff <= sample_in;
         old_ff <= old_in;
         ig_ff  <= ramp_in;
         og_ff  <= og_full[ONE_W-1:0];
      end
   end

   // clip compare and track gain product
   assign smp_wide = CLIP_W'(smp_ff);
   assign gprod_in = $signed({1'b0, gain}) * smp_ff;

   always_ff @(posedge clock) begin
      if (step.gain) begin
         gprod_ff <= gprod_in;
         hi_ff    <= (smp_wide > clip_high);
         lo_ff    <= (smp_wide < clip_low);
      end
   end

   // saturate, scale down, invert polarity
   always_comb begin
      if (hi_ff) begin
         clipped = SMAX;
      end else if (lo_ff) begin
         clipped = SMIN;
      end else begin
         clipped = gprod_ff[FB+SW-1:FB];
      end
      if (bypass) begin
         gs_in = smp_ff;
      end else if (invert) begin
         gs_in = -clipped;
      end else begin
         gs_in = clipped;
      end
   end

   always_ff @(posedge clock) begin
      if (step.pol) begin
         gs_ff <= gs_in;
      end
   end

   // fade products for new and old frame
   assign nprod_in = $signed({1'b0, ig_ff}) * gs_ff;
   assign oprod_in = $signed({1'b0, og_ff}) * old_ff;

   always_ff @(posedge clock) begin
      if (step.fade) begin
         nprod_ff <= nprod_in;
         oprod_ff <= oprod_in;
      end
   end

   // final mix, wrapping to the sample width
   assign nsh = nprod_ff[FB+SW-1:FB];
   assign osh = oprod_ff[FB+SW-1:FB];

   always_comb begin
      if (!frame.fade) begin
         sample_out = gs_ff;
      end else if (frame.xfade) begin
         sample_out = nsh + osh;
      end else begin
         sample_out = nsh;
      end
   end

endmodule

FILE: rtl/stereo_gain_fade_mixer_unit.sv
// Stereo gain/fade mixer top level: config registers, sequencer, lanes, output register.
// Depends on smx_pkg, smx_ramp and smx_lane.
//
// Usage:
//   req_* channel carries one stereo frame per beat (new samples, old-track
//   samples for the overlap, track_start and old_present flags).
//   rsp_* channel returns one processed frame per request beat, in order.
//   csr_* channel writes the eight control registers by index; it is always
//   ready and is meant to be written only while no frame is in flight.
// Pipeline: a request beat is loaded into the lanes, then passes gain multiply,
//   saturate/invert, fade multiplies and the mix into the output register.
// Sequencing: the shared sequencer steps both channel lanes through their four
//   stages one frame at a time; a new request is taken in the cycle the previous
//   result drops into the output register.
// Stall: the output register holds a finished frame while rsp_ready is low;
//   the next frame runs through the lanes and waits in its last stage until
//   the output register frees, and req_ready stays low meanwhile.
// Reset (synchronous, active high) returns registers to their defaults,
//   clears any running transition and empties the pipeline.
`timescale 1ns / 1ps

module stereo_gain_fade_mixer_unit #(
   parameter int SAMPLE_BITS    = smx_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = smx_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [smx_pkg::PORT_W-1:0]         req_left_in,
   input  logic [smx_pkg::PORT_W-1:0]         req_right_in,
   input  logic [smx_pkg::PORT_W-1:0]         req_old_left,
   input  logic [smx_pkg::PORT_W-1:0]         req_old_right,
   input  logic                               req_track_start,
   input  logic                               req_old_present,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [smx_pkg::PORT_W-1:0]         rsp_left_out,
   output logic [smx_pkg::PORT_W-1:0]         rsp_right_out,
   output logic                               rsp_fading,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smx_pkg::CSR_DATA_W-1:0]     csr_data
);
   import smx_pkg::*;

   localparam int SW = SAMPLE_BITS;
   localparam int GW = ((GAIN_FRAC_BITS + 1 > 24) ? GAIN_FRAC_BITS + 1 : 24);
   localparam int RW = ((GAIN_FRAC_BITS > 17) ? GAIN_FRAC_BITS : 17) + 1;
   localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GAIN = 5'b00010,
      S_POL  = 5'b00100,
      S_FADE = 5'b01000,
      S_DONE = 5'b10000
   } smx_state_type;

   // control registers
   logic [REPLAY_GAIN_W-1:0] replay_gain_ff;
   logic signed [CLIP_W-1:0] clip_high_ff, clip_low_ff;
   logic [POL_W-1:0]        polarity_ff;
   logic [MODE_W-1:0]       channel_mode_ff, transition_mode_ff;
   logic [RAMP_STEP_W-1:0]  ramp_step_ff;
   logic [FPS_W-1:0]        fps_ff;

   smx_state_type           state_ff, state_in;
   smx_frame_type           item_ff, frame_now;
   smx_step_type            step;
   logic                    req_fire, csr_fire, out_free;
   logic                    rsp_valid_ff;
   logic [PORT_W-1:0]       left_out_ff, right_out_ff;
   logic                    fading_ff;

   logic [GW-1:0]           gain_eff;
   logic                    bypass;
   logic signed [SW-1:0]    samp_l, samp_r, old_l, old_r, lane_l, lane_r;
   logic [RW-1:0]           ramp_gain;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         replay_gain_ff     <= REPLAY_GAIN_RST;
         clip_high_ff       <= CLIP_HIGH_RST;
         clip_low_ff        <= CLIP_LOW_RST;
         polarity_ff        <= '0;
         channel_mode_ff    <= '0;
         transition_mode_ff <= '0;
         ramp_step_ff       <= '0;
         fps_ff             <= FPS_RST;
      end else if (csr_fire) begin
         case (smx_csr_type'(csr_index))
            CSR_REPLAY_GAIN:     replay_gain_ff     <= csr_data[REPLAY_GAIN_W-1:0];
            CSR_CLIP_HIGH:       clip_high_ff       <= csr_data[CLIP_W-1:0];
            CSR_CLIP_LOW:        clip_low_ff        <= csr_data[CLIP_W-1:0];
            CSR_POLARITY:        polarity_ff        <= csr_data[POL_W-1:0];
            CSR_CHANNEL_MODE:    channel_mode_ff    <= csr_data[MODE_W-1:0];
            CSR_TRANSITION_MODE: transition_mode_ff <= csr_data[MODE_W-1:0];
            CSR_RAMP_STEP:       ramp_step_ff       <= csr_data[RAMP_STEP_W-1:0];
            CSR_FRAMES_PER_STEP: fps_ff             <= csr_data[FPS_W-1:0];
            default: ;
         endcase
      end
   end

   // zero gain means unity; unity with no inversion skips the gain stage
   assign gain_eff = (replay_gain_ff == '0) ? GAIN_ONE : GW'(replay_gain_ff);
   assign bypass   = (gain_eff == GAIN_ONE) && (polarity_ff == '0);

   // channel copy on the incoming beat
   always_comb begin
      samp_l = req_left_in[SW-1:0];
      samp_r = req_right_in[SW-1:0];
      case (channel_mode_ff)
         CH_PASS:     ;
         CH_COPY_R2L: samp_l = req_right_in[SW-1:0];
         default:     samp_r = req_left_in[SW-1:0];
      endcase
   end

   assign old_l = req_old_left[SW-1:0];
   assign old_r = req_old_right[SW-1:0];

   // sequencer
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_GAIN;
         S_GAIN: state_in = S_POL;
         S_POL:  state_in = S_FADE;
         S_FADE: state_in = S_DONE;
         S_DONE: begin
            if (req_fire) begin
               state_in = S_GAIN;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign step.load = req_fire;
   assign step.gain = (state_ff == S_GAIN);
   assign step.pol  = (state_ff == S_POL);
   assign step.fade = (state_ff == S_FADE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         item_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            item_ff <= frame_now;
         end
      end
   end

   smx_ramp #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_ramp (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_fire),
      .track_start     (req_track_start),
      .old_present     (req_old_present),
      .transition_mode (transition_mode_ff),
      .ramp_step       (ramp_step_ff),
      .frames_per_step (fps_ff),
      .frame           (frame_now),
      .ramp_gain       (ramp_gain)
   );

   smx_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_left (
      .clock      (clock),
      .step       (step),
      .frame      (item_ff),
      .gain       (gain_eff),
      .bypass     (bypass),
      .invert     (polarity_ff[0]),
      .clip_high  (clip_high_ff),
      .clip_low   (clip_low_ff),
      .sample_in  (samp_l),
      .old_in     (old_l),
      .ramp_in    (ramp_gain),
      .sample_out (lane_l)
   );

   smx_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_right (
      .clock      (clock),
      .step       (step),
      .frame      (item_ff),
      .gain       (gain_eff),
      .bypass     (bypass),
      .invert     (polarity_ff[1]),
      .clip_high  (clip_high_ff),
      .clip_low   (clip_low_ff),
      .sample_in  (samp_r),
      .old_in     (old_r),
      .ramp_in    (ramp_gain),
      .sample_out (lane_r)
   );

   // merge both lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && out_free) begin
         left_out_ff  <= PORT_W'(lane_l);
         right_out_ff <= PORT_W'(lane_r);
         fading_ff    <= item_ff.fade;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;
   assign rsp_fading    = fading_ff;

   a_accept_when_free : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ((state_ff == S_IDLE) || (state_ff == S_DONE)))
      else $error("request beat taken while lanes busy");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_GAIN))
      else $error("accepted beat did not enter the gain stage");

   a_result_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result appeared without a finished frame");

   a_done_holds : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && !out_free) |=> (state_ff == S_DONE))
      else $error("finished frame dropped while output register full");

endmodule
